### rtl/cfrr_pkg.sv
// ----------------------------------------------------------------------------
// cfrr_pkg
// Shared types and constants of the cube face round-robin scheduler.
// ----------------------------------------------------------------------------
package cfrr_pkg;

    localparam int MAX_PROBES      = 16;
    localparam int FACES_PER_PROBE = 6;

    localparam int PROBE_W = 4;
    localparam int FACE_W  = 3;
    localparam int SLICE_W = 7;
    localparam int READY_W = 5;
    localparam int COUNT_W = 5;
    localparam int STALE_W = 7;
    localparam int REQ_W   = 2;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 32;

    localparam logic [FACES_PER_PROBE-1:0] ALL_FACES = 6'h3F;
    localparam logic [FACE_W-1:0]          LAST_FACE = 3'd5;

    localparam logic REG_SET_ENABLED = 1'b0;

    typedef enum logic [REQ_W-1:0] {
        REQ_CLEAR     = 2'd0,
        REQ_ADD_PROBE = 2'd1,
        REQ_NEXT_FACE = 2'd2,
        REQ_MARK_PREF = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic capture;
        logic execute;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
    } status_t;

endpackage

### rtl/cfrr_ctrl.sv
// ----------------------------------------------------------------------------
// cfrr_ctrl
// Sequencer: capture a request, execute it, then load the result register.
// ----------------------------------------------------------------------------
module cfrr_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  cfrr_pkg::status_t status,
    output cfrr_pkg::cmd_t    cmd
);

    cfrr_pkg::state_t state_reg;
    cfrr_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cfrr_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        s_tready     = 1'b0;
        cmd.capture  = 1'b0;
        cmd.execute  = 1'b0;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            cfrr_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = cfrr_pkg::ST_EXEC;
                end
            end
            cfrr_pkg::ST_EXEC: begin
                cmd.execute = 1'b1;
                state_next  = cfrr_pkg::ST_RESULT;
            end
            cfrr_pkg::ST_RESULT: begin
                if (!status.out_busy) begin
                    cmd.load_out = 1'b1;
                    state_next   = cfrr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cfrr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/cfrr_datapath.sv
// ----------------------------------------------------------------------------
// cfrr_datapath
// Probe count, face cursor, face masks, stale counter and result register.
// ----------------------------------------------------------------------------
module cfrr_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                enabled,
    input  logic [cfrr_pkg::REQ_W-1:0]          req_in,
    input  logic [cfrr_pkg::PROBE_W-1:0]        sel_in,
    input  cfrr_pkg::cmd_t                      cmd,
    output cfrr_pkg::status_t                   status,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [cfrr_pkg::M_TDATA_W-1:0]      m_tdata
);

    localparam int NP = cfrr_pkg::MAX_PROBES;
    localparam int NF = cfrr_pkg::FACES_PER_PROBE;

    logic [cfrr_pkg::REQ_W-1:0]   req_reg;
    logic [cfrr_pkg::PROBE_W-1:0] sel_reg;

    logic [cfrr_pkg::COUNT_W-1:0] total_reg,  total_next;
    logic [cfrr_pkg::PROBE_W-1:0] cur_probe_reg, cur_probe_next;
    logic [cfrr_pkg::FACE_W-1:0]  cur_face_reg,  cur_face_next;
    logic [cfrr_pkg::SLICE_W-1:0] cursor_reg, cursor_next;
    logic [cfrr_pkg::STALE_W-1:0] stale_reg,  stale_next;
    logic [NF-1:0]                mask_reg  [NP];
    logic [NF-1:0]                mask_next [NP];

    logic                         res_acc_reg,   res_acc_next;
    logic [cfrr_pkg::PROBE_W-1:0] res_probe_reg, res_probe_next;
    logic [cfrr_pkg::FACE_W-1:0]  res_face_reg,  res_face_next;
    logic [cfrr_pkg::SLICE_W-1:0] res_slice_reg, res_slice_next;

    logic                           m_tvalid_reg;
    logic [cfrr_pkg::M_TDATA_W-1:0] m_tdata_reg;

    logic [cfrr_pkg::COUNT_W-1:0] total_inc;
    logic [cfrr_pkg::COUNT_W-1:0] total_last;
    logic [cfrr_pkg::STALE_W-1:0] total_inc_w;
    logic [cfrr_pkg::READY_W-1:0] ready_probe;

    assign total_inc   = total_reg + cfrr_pkg::COUNT_W'(1);
    assign total_last  = total_reg - cfrr_pkg::COUNT_W'(1);
    assign total_inc_w = cfrr_pkg::STALE_W'(total_inc);

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg <= req_in;
            sel_reg <= sel_in;
        end
    end

    always_comb begin
        total_next     = total_reg;
        cur_probe_next = cur_probe_reg;
        cur_face_next  = cur_face_reg;
        cursor_next    = cursor_reg;
        stale_next     = stale_reg;
        mask_next      = mask_reg;
        res_acc_next   = 1'b0;
        res_probe_next = '0;
        res_face_next  = '0;
        res_slice_next = '0;
        unique case (cfrr_pkg::req_t'(req_reg))
            cfrr_pkg::REQ_CLEAR: begin
                total_next     = '0;
                cur_probe_next = '0;
                cur_face_next  = '0;
                cursor_next    = '0;
                stale_next     = '0;
                for (int p = 0; p < NP; p++) begin
                    mask_next[p] = '0;
                end
            end
            cfrr_pkg::REQ_ADD_PROBE: begin
                if (enabled && total_reg < cfrr_pkg::COUNT_W'(NP)) begin
                    total_next     = total_inc;
                    cur_probe_next = '0;
                    cur_face_next  = '0;
                    cursor_next    = '0;
                    stale_next     = (total_inc_w << 2) + (total_inc_w << 1);
                    res_acc_next   = 1'b1;
                end
            end
            cfrr_pkg::REQ_NEXT_FACE: begin
                if (enabled && total_reg != '0) begin
                    res_acc_next   = 1'b1;
                    res_probe_next = cur_probe_reg;
                    res_face_next  = cur_face_reg;
                    res_slice_next = cursor_reg;
                    mask_next[cur_probe_reg][cur_face_reg] = 1'b1;
                    if (stale_reg != '0) begin
                        stale_next = stale_reg - cfrr_pkg::STALE_W'(1);
                    end
                    if (cur_face_reg == cfrr_pkg::LAST_FACE) begin
                        cur_face_next = '0;
                        if (cfrr_pkg::COUNT_W'(cur_probe_reg) == total_last) begin
                            cur_probe_next = '0;
                            cursor_next    = '0;
                        end else begin
                            cur_probe_next = cur_probe_reg + cfrr_pkg::PROBE_W'(1);
                            cursor_next    = cursor_reg + cfrr_pkg::SLICE_W'(1);
                        end
                    end else begin
                        cur_face_next = cur_face_reg + cfrr_pkg::FACE_W'(1);
                        cursor_next   = cursor_reg + cfrr_pkg::SLICE_W'(1);
                    end
                end
            end
            cfrr_pkg::REQ_MARK_PREF: begin
                if (cfrr_pkg::COUNT_W'(sel_reg) < cfrr_pkg::COUNT_W'(NP)) begin
                    mask_next[sel_reg] = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg     <= '0;
            cur_probe_reg <= '0;
            cur_face_reg  <= '0;
            cursor_reg    <= '0;
            stale_reg     <= '0;
            for (int p = 0; p < NP; p++) begin
                mask_reg[p] <= '0;
            end
        end else if (cmd.execute) begin
            total_reg     <= total_next;
            cur_probe_reg <= cur_probe_next;
            cur_face_reg  <= cur_face_next;
            cursor_reg    <= cursor_next;
            stale_reg     <= stale_next;
            mask_reg      <= mask_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.execute) begin
            res_acc_reg   <= res_acc_next;
            res_probe_reg <= res_probe_next;
            res_face_reg  <= res_face_next;
            res_slice_reg <= res_slice_next;
        end
    end

    always_comb begin
        ready_probe = '1;
        for (int p = NP - 1; p >= 0; p--) begin
            if (cfrr_pkg::COUNT_W'(p) < total_reg && mask_reg[p] == cfrr_pkg::ALL_FACES) begin
                ready_probe = cfrr_pkg::READY_W'(p);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_tdata_reg <= {stale_reg, total_reg, ready_probe, res_slice_reg,
                            res_face_reg, res_probe_reg, res_acc_reg};
        end
    end

    assign status.out_busy = m_tvalid_reg && !m_tready;
    assign m_tvalid        = m_tvalid_reg;
    assign m_tdata         = m_tdata_reg;

endmodule

### rtl/cube_face_round_robin_scheduler.sv
// An input transfer is captured, then executed, then loaded into the result register that drives m_tvalid.
// The controller takes one request at a time through its three-step sequence and accepts no new
// request until the load step is done; a result waiting on m_tready holds it in that step.
// Reset (aresetn low, synchronous): probe count, cursor, stale counter, all face masks
// and the enable register clear; the output channel empties.
// ----------------------------------------------------------------------------
// cube_face_round_robin_scheduler
// Round-robin scheduler of cube face captures over a set of probes.
// ----------------------------------------------------------------------------
module cube_face_round_robin_scheduler (
    input  logic        aclk,
    input  logic        aresetn,
    // probe_select [3:0]
    input  logic [7:0]  s_tdata,
    // req_type [1:0]
    input  logic [1:0]  s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // accepted [0], out_probe [4:1], out_face [7:5], out_slice [14:8],
    // ready_probe [19:15], count_now [24:20], stale_now [31:25]
    output logic [31:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic              enabled_reg;
    logic              cfg_write;
    cfrr_pkg::cmd_t    cmd;
    cfrr_pkg::status_t status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == cfrr_pkg::REG_SET_ENABLED);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg <= 1'b0;
        end else if (cfg_write) begin
            enabled_reg <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == cfrr_pkg::REG_SET_ENABLED) ? {31'b0, enabled_reg} : 32'b0;

    cfrr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    cfrr_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .enabled  (enabled_reg),
        .req_in   (s_tuser),
        .sel_in   (s_tdata[3:0]),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

### bench/cube_face_round_robin_scheduler_tb.sv
// ----------------------------------------------------------------------------
// cube_face_round_robin_scheduler_tb
// Self-checking bench for the cube face round-robin scheduler. Requests go in
// over the input stream. A predictor keeps its own probe count, face cursor,
// stale counter and face masks, and it queues the expected result of every
// transfer. Each result on the output stream is checked field by field against
// the oldest entry in that queue. Directed cases cover the disabled and full
// set, the cursor wrap, the stale floor and the ready search. Random request
// sequences follow, with random idle cycles on both streams and changes of the
// enable register between phases; an output hold-off test comes before them.
// ----------------------------------------------------------------------------
module cube_face_round_robin_scheduler_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] ADDR_SET_ENABLED = {cfrr_pkg::REG_SET_ENABLED, 2'b00};
    localparam logic [cfrr_pkg::READY_W-1:0] NO_READY = '1;
    localparam int SETTLE_CYCLES = 4;
    localparam int IDLE_LIMIT = 5000;

    typedef struct packed {
        logic [cfrr_pkg::STALE_W-1:0] stale;
        logic [cfrr_pkg::COUNT_W-1:0] count;
        logic [cfrr_pkg::READY_W-1:0] ready;
        logic [cfrr_pkg::SLICE_W-1:0] layer;
        logic [cfrr_pkg::FACE_W-1:0]  face;
        logic [cfrr_pkg::PROBE_W-1:0] probe;
        logic                         acc;
    } sched_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic [7:0]  s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic                                 set_enabled_q = 1'b0;
    logic [cfrr_pkg::COUNT_W-1:0]         probe_total_q = '0;
    logic [cfrr_pkg::SLICE_W-1:0]         cursor_q = '0;
    logic [cfrr_pkg::STALE_W-1:0]         stale_q = '0;
    logic [cfrr_pkg::FACES_PER_PROBE-1:0] masks_q [cfrr_pkg::MAX_PROBES];

    sched_result_t pending_results [$];
    int  mismatches = 0;
    int  requests_sent = 0;
    int  rx_hold = 0;
    int  idle_cycles = 0;
    bit  calm = 1'b0;

    cube_face_round_robin_scheduler dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        foreach (masks_q[p]) masks_q[p] = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
    end

    function automatic sched_result_t schedule_step(
        input cfrr_pkg::req_t req,
        input logic [cfrr_pkg::PROBE_W-1:0] sel
    );
        sched_result_t r;
        int pairs;
        int pair;
        bit found;
        r = '0;
        case (req)
            cfrr_pkg::REQ_CLEAR: begin
                probe_total_q = '0;
                cursor_q = '0;
                stale_q = '0;
                foreach (masks_q[p]) masks_q[p] = '0;
            end
            cfrr_pkg::REQ_ADD_PROBE: begin
                if (set_enabled_q && probe_total_q < cfrr_pkg::MAX_PROBES) begin
                    probe_total_q = probe_total_q + 1'b1;
                    cursor_q = '0;
                    stale_q = cfrr_pkg::STALE_W'(probe_total_q * cfrr_pkg::FACES_PER_PROBE);
                    r.acc = 1'b1;
                end
            end
            cfrr_pkg::REQ_NEXT_FACE: begin
                if (set_enabled_q && probe_total_q != 0) begin
                    pairs = probe_total_q * cfrr_pkg::FACES_PER_PROBE;
                    pair = cursor_q % pairs;
                    cursor_q = cfrr_pkg::SLICE_W'((pair + 1) % pairs);
                    masks_q[pair / cfrr_pkg::FACES_PER_PROBE] |=
                        6'(1 << (pair % cfrr_pkg::FACES_PER_PROBE));
                    if (stale_q != 0) stale_q = stale_q - 1'b1;
                    r.acc = 1'b1;
                    r.probe = cfrr_pkg::PROBE_W'(pair / cfrr_pkg::FACES_PER_PROBE);
                    r.face = cfrr_pkg::FACE_W'(pair % cfrr_pkg::FACES_PER_PROBE);
                    r.layer = cfrr_pkg::SLICE_W'(pair);
                end
            end
            default: begin
                masks_q[sel] = '0;
            end
        endcase
        r.ready = NO_READY;
        found = 1'b0;
        for (int p = 0; p < cfrr_pkg::MAX_PROBES; p++) begin
            if (!found && p < probe_total_q && masks_q[p] == cfrr_pkg::ALL_FACES) begin
                r.ready = cfrr_pkg::READY_W'(p);
                found = 1'b1;
            end
        end
        r.count = probe_total_q;
        r.stale = stale_q;
        return r;
    endfunction

    task automatic send_request(input cfrr_pkg::req_t req,
                                input logic [cfrr_pkg::PROBE_W-1:0] sel);
        while (!calm && $urandom_range(99) < 7) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {{(cfrr_pkg::S_TDATA_W-cfrr_pkg::PROBE_W){1'b0}}, sel};
        do @(posedge aclk); while (!s_tready);
        pending_results.insert(pending_results.size(), schedule_step(req, sel));
        requests_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_set_enabled(input logic value);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_SET_ENABLED;
        pwdata  <= {31'b0, value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        set_enabled_q = value;
    endtask

    task automatic test_disabled_requests();
        send_request(cfrr_pkg::REQ_NEXT_FACE, 4'd0);
        send_request(cfrr_pkg::REQ_ADD_PROBE, 4'd0);
        send_request(cfrr_pkg::REQ_MARK_PREF, 4'd15);
        send_request(cfrr_pkg::REQ_CLEAR, 4'd0);
    endtask

    task automatic test_directed_schedule();
        write_set_enabled(1'b1);
        send_request(cfrr_pkg::REQ_ADD_PROBE, 4'd0);
        repeat (7) send_request(cfrr_pkg::REQ_NEXT_FACE, 4'd0);
        send_request(cfrr_pkg::REQ_MARK_PREF, 4'd0);
        send_request(cfrr_pkg::REQ_MARK_PREF, 4'd15);
        repeat (cfrr_pkg::MAX_PROBES) send_request(cfrr_pkg::REQ_ADD_PROBE, 4'd0);
        send_request(cfrr_pkg::REQ_NEXT_FACE, 4'd15);
        send_request(cfrr_pkg::REQ_CLEAR, 4'd15);
    endtask

    task automatic test_enable_toggle();
        send_request(cfrr_pkg::REQ_ADD_PROBE, 4'd0);
        send_request(cfrr_pkg::REQ_ADD_PROBE, 4'd0);
        repeat (8) send_request(cfrr_pkg::REQ_NEXT_FACE, 4'($urandom_range(15)));
        write_set_enabled(1'b0);
        send_request(cfrr_pkg::REQ_NEXT_FACE, 4'd0);
        send_request(cfrr_pkg::REQ_ADD_PROBE, 4'd0);
        send_request(cfrr_pkg::REQ_MARK_PREF, 4'd1);
        write_set_enabled(1'b1);
        repeat (6) send_request(cfrr_pkg::REQ_NEXT_FACE, 4'd0);
        write_set_enabled(1'b0);
        write_set_enabled(1'b1);
    endtask

    task automatic test_output_stall();
        rx_hold = 400;
        send_request(cfrr_pkg::REQ_CLEAR, 4'd0);
        repeat (3) send_request(cfrr_pkg::REQ_ADD_PROBE, 4'd0);
        repeat (40) send_request(cfrr_pkg::REQ_NEXT_FACE, 4'($urandom_range(15)));
        drain();
        repeat (20) send_request(cfrr_pkg::REQ_NEXT_FACE, 4'($urandom_range(15)));
    endtask

    task automatic test_random_sequences(input int count);
        int stop_at;
        int n;
        int steps;
        stop_at = requests_sent + count;
        while (requests_sent < stop_at) begin
            if ($urandom_range(9) == 0) begin
                repeat ($urandom_range(1, 8))
                    send_request(cfrr_pkg::req_t'($urandom_range(3)),
                                 4'($urandom_range(15)));
            end else begin
                if ($urandom_range(1) == 0)
                    send_request(cfrr_pkg::REQ_CLEAR, 4'($urandom_range(15)));
                n = ($urandom_range(7) == 0) ? cfrr_pkg::MAX_PROBES : $urandom_range(1, 5);
                repeat (n) send_request(cfrr_pkg::REQ_ADD_PROBE, 4'($urandom_range(15)));
                steps = $urandom_range(1, n * cfrr_pkg::FACES_PER_PROBE + 8);
                repeat (steps) begin
                    case ($urandom_range(19))
                        0: send_request(cfrr_pkg::REQ_ADD_PROBE, 4'($urandom_range(15)));
                        1, 2: send_request(cfrr_pkg::REQ_MARK_PREF,
                                           4'($urandom_range(n - 1)));
                        default: send_request(cfrr_pkg::REQ_NEXT_FACE,
                                              4'($urandom_range(15)));
                    endcase
                end
            end
        end
    endtask

    task automatic flag_mismatch(input string field, input int want, input int got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s: expected %0d, got %0d", field, want, got);
    endtask

    always @(posedge aclk) begin
        if (rx_hold != 0) begin
            rx_hold--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(99) >= 7);
        end
    end

    always @(posedge aclk) begin
        sched_result_t got;
        sched_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_results.size() == 0) begin
                flag_mismatch("unexpected transfer", 0, int'(m_tdata));
            end else begin
                want = pending_results.pop_front();
                if (got.acc !== want.acc) flag_mismatch("accepted", want.acc, got.acc);
                if (got.probe !== want.probe) flag_mismatch("out_probe", want.probe, got.probe);
                if (got.face !== want.face) flag_mismatch("out_face", want.face, got.face);
                if (got.layer !== want.layer) flag_mismatch("out_slice", want.layer, got.layer);
                if (got.ready !== want.ready)
                    flag_mismatch("ready_probe", $signed(want.ready), $signed(got.ready));
                if (got.count !== want.count) flag_mismatch("count_now", want.count, got.count);
                if (got.stale !== want.stale) flag_mismatch("stale_now", want.stale, got.stale);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        while (!aresetn) @(posedge aclk);
        test_disabled_requests();
        test_directed_schedule();
        test_enable_toggle();
        test_output_stall();
        calm = 1'b1;
        test_random_sequences(300);
        calm = 1'b0;
        test_random_sequences(300);
        write_set_enabled(1'b0);
        test_random_sequences(40);
        write_set_enabled(1'b1);
        test_random_sequences(300);
        drain();
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
